@@ rtl/core/ppp_pkg.sv @@
// ----------------------------------------------------------------------------
// ppp_pkg
// Types and constants shared by the perspective point projection pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

   localparam int COORD_W  = 32;
   localparam int COEF_W   = 21;
   localparam int ROW_W    = 3 * COEF_W;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = COEF_W + DIFF_W;
   localparam int MAG_W    = 56;
   localparam int LOW_W    = 16;
   localparam int QUO_W    = 32;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [MAG_W-1:0] ONE_Q33 = MAG_W'(1) << 33;
   localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

   localparam logic [2:0] REG_ROW_ZERO = 3'd0;
   localparam logic [2:0] REG_ROW_ONE  = 3'd1;
   localparam logic [2:0] REG_ROW_TWO  = 3'd2;
   localparam logic [2:0] REG_CENTER_X = 3'd3;
   localparam logic [2:0] REG_CENTER_Y = 3'd4;
   localparam logic [2:0] REG_CENTER_Z = 3'd5;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] image_x;
      logic signed [COORD_W-1:0] image_y;
      logic signed [COORD_W-1:0] inverse_depth;
      logic                      depth_zero;
   } rsp_type;

   // One numerator in flight through the divider.
   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [LOW_W-1:0] low;
      logic [QUO_W-1:0] quo;
      logic             huge;
      logic             neg;
      logic             num_neg;
      logic             num_zero;
   } num_type;

   typedef struct packed {
      num_type [2:0]    num;
      logic [MAG_W-1:0] den;
      logic             dz;
   } div_type;

endpackage

@@ rtl/core/ppp_div_step.sv @@
// ----------------------------------------------------------------------------
// ppp_div_step
// One registered restoring-division step for the three numerators that share
// the projected depth as divisor.
// ----------------------------------------------------------------------------
module ppp_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ppp_pkg::div_type in_data,
   output logic             out_valid,
   output ppp_pkg::div_type out_data
);

   logic             valid_ff;
   ppp_pkg::div_type data_ff;
   ppp_pkg::div_type data_in;

   always_comb begin
      logic [ppp_pkg::MAG_W:0] part;
      logic [ppp_pkg::MAG_W:0] diff;
      data_in = in_data;
      for (int j = 0; j < 3; j++) begin
         part = {in_data.num[j].rem, in_data.num[j].low[ppp_pkg::LOW_W-1]};
         diff = part - {1'b0, in_data.den};
         data_in.num[j].low = {in_data.num[j].low[ppp_pkg::LOW_W-2:0], 1'b0};
         if (!diff[ppp_pkg::MAG_W]) begin
            data_in.num[j].rem = diff[ppp_pkg::MAG_W-1:0];
            data_in.num[j].quo = {in_data.num[j].quo[ppp_pkg::QUO_W-2:0], 1'b1};
         end else begin
            data_in.num[j].rem = part[ppp_pkg::MAG_W-1:0];
            data_in.num[j].quo = {in_data.num[j].quo[ppp_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/core/perspective_point_projection.sv @@
// ----------------------------------------------------------------------------
// perspective_point_projection
// Pinhole projection of one world point per clock into image coordinates.
// ----------------------------------------------------------------------------
// A point is transferred in at a rising edge where req_start is high and
// req_busy is low; req_busy is high only while reset is applied. The camera
// centre is subtracted, the offset is multiplied by the 3x3 matrix held in the
// csr registers and the two image coordinates and the inverse depth are formed
// by division by the projected depth, each truncated and saturated to Q16.16.
// Registers are written with csr_we, csr_index and csr_wdata; the user must
// do so only while no point is in flight, which the block does not enforce;
// indexes above five are ignored. A new point may be taken in every cycle.
// Each result appears on rsp_data with rsp_strobe for one cycle, after the
// point has passed five stages of subtract, multiply, sum, magnitude and
// set-up, then 32 single-bit division stages and the output register. The
// receiver cannot hold results off, so nothing ever stalls.
// Reset clears the registers to zero and drops every point in flight.
// ----------------------------------------------------------------------------
module perspective_point_projection (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_start,
   output logic                            req_busy,
   input  ppp_pkg::req_type                req_data,
   output logic                            rsp_strobe,
   output ppp_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [2:0]                      csr_index,
   input  logic [ppp_pkg::ROW_W-1:0]       csr_wdata
);

   logic [ppp_pkg::ROW_W-1:0]          row_ff [3];
   logic signed [ppp_pkg::COORD_W-1:0] center_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            row_ff[i]    <= '0;
            center_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            ppp_pkg::REG_ROW_ZERO: row_ff[0] <= csr_wdata;
            ppp_pkg::REG_ROW_ONE:  row_ff[1] <= csr_wdata;
            ppp_pkg::REG_ROW_TWO:  row_ff[2] <= csr_wdata;
            ppp_pkg::REG_CENTER_X: center_ff[0] <= csr_wdata[ppp_pkg::COORD_W-1:0];
            ppp_pkg::REG_CENTER_Y: center_ff[1] <= csr_wdata[ppp_pkg::COORD_W-1:0];
            ppp_pkg::REG_CENTER_Z: center_ff[2] <= csr_wdata[ppp_pkg::COORD_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_busy = reset;

   // Stage 1: offset from the camera centre.
   logic                              s1_valid_ff;
   logic signed [ppp_pkg::DIFF_W-1:0] diff_ff [3];
   logic signed [ppp_pkg::COORD_W-1:0] point [3];

   assign point[0] = req_data.point_x;
   assign point[1] = req_data.point_y;
   assign point[2] = req_data.point_z;

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         diff_ff[c] <= ppp_pkg::DIFF_W'(point[c]) - ppp_pkg::DIFF_W'(center_ff[c]);
      end
   end

   // Stage 2: nine products.
   logic                              s2_valid_ff;
   logic signed [ppp_pkg::PROD_W-1:0] prod_ff [3][3];

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[r][c] <= $signed(row_ff[r][ppp_pkg::COEF_W*c +: ppp_pkg::COEF_W])
                             * diff_ff[c];
         end
      end
   end

   // Stage 3: row sums.
   logic                             s3_valid_ff;
   logic signed [ppp_pkg::MAG_W-1:0] sum_ff [3];

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         sum_ff[r] <= ppp_pkg::MAG_W'(prod_ff[r][0]) + ppp_pkg::MAG_W'(prod_ff[r][1])
                      + ppp_pkg::MAG_W'(prod_ff[r][2]);
      end
   end

   // Stage 4: magnitudes and signs.
   logic                     s4_valid_ff;
   logic [ppp_pkg::MAG_W-1:0] num_mag_ff [3];
   logic                     num_neg_ff [3];
   logic [ppp_pkg::MAG_W-1:0] den_mag_ff;
   logic                     den_neg_ff;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         num_neg_ff[j] <= sum_ff[j][ppp_pkg::MAG_W-1];
         num_mag_ff[j] <= sum_ff[j][ppp_pkg::MAG_W-1] ? ppp_pkg::MAG_W'(-sum_ff[j])
                                                      : ppp_pkg::MAG_W'(sum_ff[j]);
      end
      num_neg_ff[2] <= 1'b0;
      num_mag_ff[2] <= ppp_pkg::ONE_Q33;
      den_neg_ff    <= sum_ff[2][ppp_pkg::MAG_W-1];
      den_mag_ff    <= sum_ff[2][ppp_pkg::MAG_W-1] ? ppp_pkg::MAG_W'(-sum_ff[2])
                                                   : ppp_pkg::MAG_W'(sum_ff[2]);
   end

   // Stage 5: split each numerator for the divider and flag overflow early.
   logic             s5_valid_ff;
   ppp_pkg::div_type div_ff;
   ppp_pkg::div_type div_in;

   always_comb begin
      logic [ppp_pkg::MAG_W-1:0] top;
      div_in.den = den_mag_ff;
      div_in.dz  = (den_mag_ff == '0);
      for (int j = 0; j < 3; j++) begin
         top = num_mag_ff[j] >> ppp_pkg::LOW_W;
         div_in.num[j].rem      = top;
         div_in.num[j].low      = num_mag_ff[j][ppp_pkg::LOW_W-1:0];
         div_in.num[j].quo      = '0;
         div_in.num[j].huge     = (top >= den_mag_ff);
         div_in.num[j].neg      = num_neg_ff[j] != den_neg_ff;
         div_in.num[j].num_neg  = num_neg_ff[j];
         div_in.num[j].num_zero = (num_mag_ff[j] == '0);
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_start && !req_busy;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Division: one quotient bit per stage.
   logic             step_valid [ppp_pkg::DIV_STEPS+1];
   ppp_pkg::div_type step_data  [ppp_pkg::DIV_STEPS+1];

   assign step_valid[0] = s5_valid_ff;
   assign step_data[0]  = div_ff;

   for (genvar k = 0; k < ppp_pkg::DIV_STEPS; k++) begin : g_step
      ppp_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[k]),
         .in_data   (step_data[k]),
         .out_valid (step_valid[k+1]),
         .out_data  (step_data[k+1])
      );
   end

   // Output stage: sign and saturation.
   logic                               out_valid_ff;
   ppp_pkg::rsp_type                   out_ff;
   logic [ppp_pkg::COORD_W-1:0]        res [3];
   ppp_pkg::div_type                   fin;

   assign fin = step_data[ppp_pkg::DIV_STEPS];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (fin.dz) begin
            if (fin.num[j].num_zero) begin
               res[j] = '0;
            end else if (fin.num[j].num_neg) begin
               res[j] = ppp_pkg::SAT_NEG;
            end else begin
               res[j] = ppp_pkg::SAT_POS;
            end
         end else if (fin.num[j].neg) begin
            res[j] = (fin.num[j].huge || fin.num[j].quo[ppp_pkg::QUO_W-1])
                     ? ppp_pkg::SAT_NEG : -fin.num[j].quo;
         end else begin
            res[j] = (fin.num[j].huge || fin.num[j].quo[ppp_pkg::QUO_W-1])
                     ? ppp_pkg::SAT_POS : fin.num[j].quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff.image_x       <= res[0];
      out_ff.image_y       <= res[1];
      out_ff.inverse_depth <= res[2];
      out_ff.depth_zero    <= fin.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= step_valid[ppp_pkg::DIV_STEPS];
      end
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_ff;

endmodule

@@ rtl/core/ppp_checker.sv @@
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks on latency, reset and zero-depth saturation.
// ----------------------------------------------------------------------------
module ppp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_start,
   input logic             req_busy,
   input logic             rsp_strobe,
   input ppp_pkg::rsp_type rsp_data
);

   localparam int LATENCY = 38;

   logic       accepted;
   logic [5:0] settle_ff;
   logic [5:0] settle_in;

   assign accepted  = req_start && !req_busy;
   assign settle_in = (settle_ff == 6'(LATENCY)) ? settle_ff : settle_ff + 6'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
      end else begin
         settle_ff <= settle_in;
      end
   end

   // Every transfer in gives exactly one result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (settle_ff == 6'(LATENCY)) |-> (rsp_strobe == $past(accepted, LATENCY)))
      else $error("result strobe does not follow accepted point");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.depth_zero) |-> (rsp_data.inverse_depth == ppp_pkg::SAT_POS))
      else $error("zero depth without saturated inverse depth");

   a_zero_num: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.depth_zero) |->
      (rsp_data.image_x == '0 || rsp_data.image_x == ppp_pkg::SAT_POS
       || rsp_data.image_x == ppp_pkg::SAT_NEG))
      else $error("zero depth with unsaturated image x");

endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_start  (req_start),
   .req_busy   (req_busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
